[sv/isa_pkg.sv]
// Shared types and constants for the index set submatrix accumulate unit.
// Holds command codes, controller states, command and status structs.
// No dependencies.
package isa_pkg;

  localparam int unsigned VALUE_W    = 64;
  localparam int unsigned IDX_W      = 6;
  localparam int unsigned CMD_W      = 3;
  localparam int unsigned IN_DATA_W  = 80;
  localparam int unsigned OUT_USER_W = 2;

  localparam logic [VALUE_W-1:0] Q_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [VALUE_W-1:0] Q_MIN = 64'h8000_0000_0000_0000;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH   = 3'd0,
    CMD_ADD    = 3'd1,
    CMD_SET    = 3'd2,
    CMD_MIRROR = 3'd3,
    CMD_READ   = 3'd4
  } cmd_code_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ_OUT,
    ST_FETCH,
    ST_PAIR,
    ST_CELL_WR,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    WS_ZERO,
    WS_VALUE,
    WS_SUM,
    WS_COPY
  } wsel_t;

  typedef enum logic [1:0] {
    OS_FLAGS,
    OS_READ,
    OS_BULK
  } osel_t;

  typedef struct packed {
    logic  take;
    logic  list_wr;
    logic  list_rd;
    logic  mat_rd_item;
    logic  mat_rd_pair;
    logic  mat_wr;
    logic  wr_cross;
    wsel_t wsel;
    logic  out_load;
    osel_t osel;
    logic  full_flag;
  } ctrl_cmd_t;

  typedef struct packed {
    logic pair_ok;
    logic out_busy;
  } dp_status_t;

endpackage

[sv/index_set_submatrix_accumulate_unit.sv]
// Top level of the index set submatrix accumulate unit.
// Joins the controller and the datapath. Depends on isa_pkg, isa_ctrl, isa_dpath.
//
//   channel   dir  signals                         payload
//   s_*       in   s_tvalid s_tready s_tdata s_tuser  command, index, column, value
//   m_*       out  m_tvalid m_tready m_tdata m_tuser  read value, flags
//
// Push and unused codes load a result from idle; read goes through a read-out state.
// Add and mirror pass fetch, pair and cell write states per listed pair, set fetch and pair;
// a pair that names an index at or beyond DIM is skipped with no matrix access. The pair loop
// runs through the one read port and one write port of the matrix RAM.
// After reset a clearing pass zeroes the matrix; no item is taken.
// The result register holds one result; a new item waits while it stays untaken.
module index_set_submatrix_accumulate_unit import isa_pkg::*; #(
  parameter int unsigned DIM = 64,
  parameter int unsigned MAX_SET = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // element_index [5:0], read_column [11:6], value [75:12], zero [79:76]
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // command [2:0]
  input  logic [CMD_W-1:0]      s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // read_value [63:0]
  output logic [VALUE_W-1:0]    m_tdata,
  // saturated [0], list_full [1]
  output logic [OUT_USER_W-1:0] m_tuser
);

  localparam int unsigned LW = (MAX_SET > 1) ? $clog2(MAX_SET) : 1;
  localparam int unsigned AW = $clog2(DIM * DIM);

  ctrl_cmd_t     cmd;
  dp_status_t    status;
  logic [LW-1:0] list_wr_addr;
  logic [LW-1:0] list_addr_i;
  logic [LW-1:0] list_addr_j;
  logic [AW-1:0] clr_addr;

  isa_ctrl #(.DIM(DIM), .MAX_SET(MAX_SET)) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tuser      (s_tuser),
    .status       (status),
    .cmd          (cmd),
    .list_wr_addr (list_wr_addr),
    .list_addr_i  (list_addr_i),
    .list_addr_j  (list_addr_j),
    .clr_addr     (clr_addr)
  );

  isa_dpath #(.DIM(DIM), .MAX_SET(MAX_SET)) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .s_tdata      (s_tdata),
    .cmd          (cmd),
    .status       (status),
    .list_wr_addr (list_wr_addr),
    .list_addr_i  (list_addr_i),
    .list_addr_j  (list_addr_j),
    .clr_addr     (clr_addr),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .m_tuser      (m_tuser)
  );

endmodule

[sv/isa_ram.sv]
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module isa_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[sv/isa_ctrl.sv]
// Controller state machine: clearing pass, command decode, pair loop counters
// and the index count. Depends on isa_pkg.
module isa_ctrl import isa_pkg::*; #(
  parameter int unsigned DIM = 64,
  parameter int unsigned MAX_SET = 64,
  localparam int unsigned LW = (MAX_SET > 1) ? $clog2(MAX_SET) : 1,
  localparam int unsigned CW = $clog2(MAX_SET + 1),
  localparam int unsigned AW = $clog2(DIM * DIM)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [CMD_W-1:0] s_tuser,
  input  dp_status_t       status,
  output ctrl_cmd_t        cmd,
  output logic [LW-1:0]    list_wr_addr,
  output logic [LW-1:0]    list_addr_i,
  output logic [LW-1:0]    list_addr_j,
  output logic [AW-1:0]    clr_addr
);

  state_t        state, state_next;
  cmd_code_t     op, op_next;
  cmd_code_t     cmd_in;
  logic [LW-1:0] i, i_next;
  logic [LW-1:0] j, j_next;
  logic [CW-1:0] count, count_next;
  logic [AW-1:0] clr, clr_next;
  logic          advance;
  logic          j_end;
  logic          i_last;

  assign cmd_in       = cmd_code_t'(s_tuser);
  assign list_wr_addr = count[LW-1:0];
  assign list_addr_i  = i;
  assign list_addr_j  = j;
  assign clr_addr     = clr;

  assign j_end  = (op == CMD_MIRROR) ? (((LW+1)'(j) + 1'b1) == (LW+1)'(i)) : (j == i);
  assign i_last = ((CW+1)'(i) + 1'b1) == (CW+1)'(count);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      op    <= CMD_PUSH;
      i     <= '0;
      j     <= '0;
      count <= '0;
      clr   <= '0;
    end else begin
      state <= state_next;
      op    <= op_next;
      i     <= i_next;
      j     <= j_next;
      count <= count_next;
      clr   <= clr_next;
    end
  end

  always_comb begin
    state_next = state;
    op_next    = op;
    i_next     = i;
    j_next     = j;
    count_next = count;
    clr_next   = clr;
    cmd        = '0;
    s_tready   = 1'b0;
    advance    = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        cmd.mat_wr = 1'b1;
        cmd.wsel   = WS_ZERO;
        if (clr == AW'(DIM * DIM - 1)) begin
          state_next = ST_IDLE;
        end else begin
          clr_next = clr + 1'b1;
        end
      end
      ST_IDLE: begin
        s_tready = !status.out_busy;
        if (s_tvalid && !status.out_busy) begin
          cmd.take = 1'b1;
          op_next  = cmd_in;
          unique case (cmd_in) inside
            CMD_PUSH: begin
              cmd.out_load = 1'b1;
              cmd.osel     = OS_FLAGS;
              if (count < CW'(MAX_SET)) begin
                cmd.list_wr = 1'b1;
                count_next  = count + 1'b1;
              end else begin
                cmd.full_flag = 1'b1;
              end
            end
            CMD_ADD, CMD_SET: begin
              i_next     = '0;
              j_next     = '0;
              state_next = (count == '0) ? ST_DONE : ST_FETCH;
            end
            CMD_MIRROR: begin
              i_next     = LW'(1);
              j_next     = '0;
              state_next = (count <= CW'(1)) ? ST_DONE : ST_FETCH;
            end
            CMD_READ: begin
              cmd.mat_rd_item = 1'b1;
              state_next      = ST_READ_OUT;
            end
            default: begin
              cmd.out_load = 1'b1;
              cmd.osel     = OS_FLAGS;
            end
          endcase
        end
      end
      ST_READ_OUT: begin
        cmd.out_load = 1'b1;
        cmd.osel     = OS_READ;
        state_next   = ST_IDLE;
      end
      ST_FETCH: begin
        cmd.list_rd = 1'b1;
        state_next  = ST_PAIR;
      end
      ST_PAIR: begin
        if (!status.pair_ok) begin
          advance = 1'b1;
        end else if (op == CMD_SET) begin
          cmd.mat_wr = 1'b1;
          cmd.wsel   = WS_VALUE;
          advance    = 1'b1;
        end else begin
          cmd.mat_rd_pair = 1'b1;
          state_next      = ST_CELL_WR;
        end
      end
      ST_CELL_WR: begin
        cmd.mat_wr   = 1'b1;
        cmd.wsel     = (op == CMD_MIRROR) ? WS_COPY : WS_SUM;
        cmd.wr_cross = (op == CMD_MIRROR);
        advance      = 1'b1;
      end
      ST_DONE: begin
        cmd.out_load = 1'b1;
        cmd.osel     = OS_BULK;
        count_next   = '0;
        state_next   = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
    if (advance) begin
      if (j_end) begin
        if (i_last) begin
          state_next = ST_DONE;
        end else begin
          i_next     = i + 1'b1;
          j_next     = '0;
          state_next = ST_FETCH;
        end
      end else begin
        j_next     = j + 1'b1;
        state_next = ST_FETCH;
      end
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_SET))
    else $error("index count beyond list depth");

  a_done_empties: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE) |=> (count == '0 && state == ST_IDLE))
    else $error("bulk command did not empty the list");

  a_read_result: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && cmd_in == CMD_READ) |=> (state == ST_READ_OUT && cmd.out_load))
    else $error("read item did not produce its result");

  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PAIR || state == ST_CELL_WR) |-> (j <= i))
    else $error("column position passed row position");
`endif

endmodule

[sv/isa_dpath.sv]
// Datapath: index list RAMs, matrix RAM, saturating adder and result register.
// Depends on isa_pkg and isa_ram.
module isa_dpath import isa_pkg::*; #(
  parameter int unsigned DIM = 64,
  parameter int unsigned MAX_SET = 64,
  localparam int unsigned LW = (MAX_SET > 1) ? $clog2(MAX_SET) : 1,
  localparam int unsigned AW = $clog2(DIM * DIM)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [IN_DATA_W-1:0]  s_tdata,
  input  ctrl_cmd_t             cmd,
  output dp_status_t            status,
  input  logic [LW-1:0]         list_wr_addr,
  input  logic [LW-1:0]         list_addr_i,
  input  logic [LW-1:0]         list_addr_j,
  input  logic [AW-1:0]         clr_addr,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [VALUE_W-1:0]    m_tdata,
  output logic [OUT_USER_W-1:0] m_tuser
);

  logic [IDX_W-1:0]   in_eidx;
  logic [IDX_W-1:0]   in_rcol;
  logic [VALUE_W-1:0] in_value;
  logic [VALUE_W-1:0] value_q;
  logic               sat_q;
  logic               rd_ok_q;
  logic [IDX_W-1:0]   row_idx;
  logic [IDX_W-1:0]   col_idx;
  logic               item_ok;
  logic [AW-1:0]      item_addr;
  logic [AW-1:0]      pair_rc;
  logic [AW-1:0]      pair_cr;
  logic               mat_rd_en;
  logic [AW-1:0]      mat_rd_addr;
  logic [AW-1:0]      mat_wr_addr;
  logic [VALUE_W-1:0] mat_wr_data;
  logic [VALUE_W-1:0] mat_rdata;
  logic [VALUE_W-1:0] sum;
  logic               sum_ovf;
  logic [VALUE_W-1:0] sum_sat;

  assign in_eidx  = s_tdata[IDX_W-1:0];
  assign in_rcol  = s_tdata[2*IDX_W-1:IDX_W];
  assign in_value = s_tdata[2*IDX_W+VALUE_W-1:2*IDX_W];

  isa_ram #(.WIDTH(IDX_W), .DEPTH(MAX_SET)) u_list_row (
    .clk     (clk),
    .wr_en   (cmd.list_wr),
    .wr_addr (list_wr_addr),
    .wr_data (in_eidx),
    .rd_en   (cmd.list_rd),
    .rd_addr (list_addr_i),
    .rd_data (row_idx)
  );

  isa_ram #(.WIDTH(IDX_W), .DEPTH(MAX_SET)) u_list_col (
    .clk     (clk),
    .wr_en   (cmd.list_wr),
    .wr_addr (list_wr_addr),
    .wr_data (in_eidx),
    .rd_en   (cmd.list_rd),
    .rd_addr (list_addr_j),
    .rd_data (col_idx)
  );

  assign status.pair_ok  = (32'(row_idx) < DIM) && (32'(col_idx) < DIM);
  assign status.out_busy = m_tvalid && !m_tready;

  assign pair_rc   = AW'(32'(row_idx) * DIM + 32'(col_idx));
  assign pair_cr   = AW'(32'(col_idx) * DIM + 32'(row_idx));
  assign item_ok   = (32'(in_eidx) < DIM) && (32'(in_rcol) < DIM);
  assign item_addr = AW'(32'(in_eidx) * DIM + 32'(in_rcol));

  assign mat_rd_en   = cmd.mat_rd_item || cmd.mat_rd_pair;
  assign mat_rd_addr = cmd.mat_rd_item ? item_addr : pair_rc;

  always_comb begin
    if (cmd.wsel == WS_ZERO) begin
      mat_wr_addr = clr_addr;
    end else if (cmd.wr_cross) begin
      mat_wr_addr = pair_cr;
    end else begin
      mat_wr_addr = pair_rc;
    end
  end

  assign sum     = mat_rdata + value_q;
  assign sum_ovf = (mat_rdata[VALUE_W-1] == value_q[VALUE_W-1]) &&
                   (sum[VALUE_W-1] != mat_rdata[VALUE_W-1]);
  assign sum_sat = sum_ovf ? (mat_rdata[VALUE_W-1] ? Q_MIN : Q_MAX) : sum;

  always_comb begin
    case (cmd.wsel)
      WS_ZERO:  mat_wr_data = '0;
      WS_VALUE: mat_wr_data = value_q;
      WS_SUM:   mat_wr_data = sum_sat;
      WS_COPY:  mat_wr_data = mat_rdata;
      default:  mat_wr_data = '0;
    endcase
  end

  isa_ram #(.WIDTH(VALUE_W), .DEPTH(DIM * DIM)) u_matrix (
    .clk     (clk),
    .wr_en   (cmd.mat_wr),
    .wr_addr (mat_wr_addr),
    .wr_data (mat_wr_data),
    .rd_en   (mat_rd_en),
    .rd_addr (mat_rd_addr),
    .rd_data (mat_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      value_q <= in_value;
      rd_ok_q <= item_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sat_q    <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (cmd.take) begin
        sat_q <= 1'b0;
      end else if (cmd.mat_wr && cmd.wsel == WS_SUM && sum_ovf) begin
        sat_q <= 1'b1;
      end
      if (cmd.out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      case (cmd.osel)
        OS_READ: begin
          m_tdata <= rd_ok_q ? mat_rdata : '0;
          m_tuser <= '0;
        end
        OS_BULK: begin
          m_tdata <= '0;
          m_tuser <= {1'b0, sat_q};
        end
        default: begin
          m_tdata <= '0;
          m_tuser <= {cmd.full_flag, 1'b0};
        end
      endcase
    end
  end

endmodule

[test/tb_index_set_submatrix_accumulate_unit.sv]
// Self-checking testbench for index_set_submatrix_accumulate_unit.
// An in-order predictor of the matrix and index list checks every result of the stream.
// Depends on isa_pkg and the unit's RTL only.
`timescale 1ns / 100ps

module tb_index_set_submatrix_accumulate_unit;
  import isa_pkg::*;

  localparam int DIM = 64;
  localparam int MAX_SET = 64;
  localparam int RANDOM_ITEMS = 650;
  localparam int MAX_WAIT = 12;
  localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_LAST = 3'd7;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DIM - 1);

  typedef struct packed {
    logic [VALUE_W-1:0] data;
    logic sat;
    logic full;
  } outcome_t;

  logic clk;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [IN_DATA_W-1:0] s_tdata;
  logic [CMD_W-1:0] s_tuser;
  logic m_tvalid;
  logic m_tready;
  logic [VALUE_W-1:0] m_tdata;
  logic [OUT_USER_W-1:0] m_tuser;

  logic [VALUE_W-1:0] cells [DIM][DIM];
  logic [IDX_W-1:0] set_list [MAX_SET];
  int set_len;
  outcome_t pending_results [$];

  int error_count = 0;
  int items_sent = 0;
  int bulk_count = 0;
  int results_checked = 0;
  int sat_seen = 0;
  int full_seen = 0;
  bit send_quiet = 1'b0;
  bit recv_quiet = 1'b0;

  index_set_submatrix_accumulate_unit #(
    .DIM(DIM),
    .MAX_SET(MAX_SET)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int draw_wait(inout bit quiet);
    if ($urandom_range(0, 31) == 0) quiet = !quiet;
    if (quiet) return 0;
    return $urandom_range(0, MAX_WAIT);
  endfunction

  function automatic logic [VALUE_W-1:0] draw_amount();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 9))
      0: return Q_MAX;
      1: return Q_MIN;
      2: return '0;
      3: return '1;
      4: return 64'd1;
      5, 6: return {{32{r[31]}}, r};
      default: return {$urandom, r};
    endcase
  endfunction

  function automatic void clear_model();
    for (int r = 0; r < DIM; r++) begin
      for (int c = 0; c < DIM; c++) begin
        cells[r][c] = '0;
      end
    end
    set_len = 0;
  endfunction

  function automatic outcome_t apply_command(input logic [CMD_W-1:0] code,
                                             input logic [IDX_W-1:0] row,
                                             input logic [IDX_W-1:0] col,
                                             input logic [VALUE_W-1:0] amount);
    outcome_t res;
    logic [IDX_W-1:0] r;
    logic [IDX_W-1:0] c;
    logic [VALUE_W-1:0] old;
    logic [VALUE_W-1:0] sum;
    res = '0;
    case (code)
      CMD_PUSH: begin
        if (set_len < MAX_SET) begin
          set_list[set_len] = row;
          set_len++;
        end else begin
          res.full = 1'b1;
        end
      end
      CMD_ADD, CMD_SET: begin
        for (int i = 0; i < set_len; i++) begin
          for (int j = 0; j <= i; j++) begin
            r = set_list[i];
            c = set_list[j];
            if (code == CMD_ADD) begin
              old = cells[r][c];
              sum = old + amount;
              if (old[VALUE_W-1] == amount[VALUE_W-1] && sum[VALUE_W-1] != old[VALUE_W-1]) begin
                res.sat = 1'b1;
                sum = old[VALUE_W-1] ? Q_MIN : Q_MAX;
              end
              cells[r][c] = sum;
            end else begin
              cells[r][c] = amount;
            end
          end
        end
        set_len = 0;
      end
      CMD_MIRROR: begin
        for (int i = 1; i < set_len; i++) begin
          for (int j = 0; j < i; j++) begin
            r = set_list[i];
            c = set_list[j];
            cells[c][r] = cells[r][c];
          end
        end
        set_len = 0;
      end
      CMD_READ: begin
        res.data = cells[row][col];
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [VALUE_W-1:0] got,
                                 input logic [VALUE_W-1:0] want);
    $display("MISMATCH at %0t, result %0d, %s: got %h, expected %h",
             $time, results_checked, what, got, want);
    error_count++;
  endtask

  task automatic send_item(input logic [CMD_W-1:0] code, input logic [IDX_W-1:0] row,
                           input logic [IDX_W-1:0] col, input logic [VALUE_W-1:0] amount);
    int gap;
    gap = draw_wait(send_quiet);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= code;
    s_tdata <= {{(IN_DATA_W - VALUE_W - 2 * IDX_W){1'b0}}, amount, col, row};
    do @(posedge clk); while (!s_tready);
    pending_results.push_back(apply_command(code, row, col, amount));
    if (code < CMD_SPARE_FIRST) items_sent++;
    if (code == CMD_ADD || code == CMD_SET || code == CMD_MIRROR) bulk_count++;
  endtask

  always @(posedge clk) begin
    outcome_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with no item pending", m_tdata, '0);
      end else begin
        want = pending_results.pop_front();
        if (m_tdata !== want.data) report_mismatch("read_value", m_tdata, want.data);
        if (m_tuser[0] !== want.sat) begin
          report_mismatch("saturated", VALUE_W'(m_tuser[0]), VALUE_W'(want.sat));
        end
        if (m_tuser[1] !== want.full) begin
          report_mismatch("list_full", VALUE_W'(m_tuser[1]), VALUE_W'(want.full));
        end
        sat_seen += int'(want.sat);
        full_seen += int'(want.full);
        results_checked++;
      end
    end
  end

  initial begin
    int stall;
    m_tready = 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      stall = draw_wait(recv_quiet);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  task automatic test_reads_after_reset();
    send_item(CMD_READ, 0, 0, Q_MAX);
    send_item(CMD_READ, LAST_IDX, LAST_IDX, '1);
    send_item(CMD_READ, LAST_IDX, 0, Q_MIN);
  endtask

  task automatic test_set_and_saturating_add();
    send_item(CMD_PUSH, LAST_IDX, 0, '0);
    send_item(CMD_PUSH, 0, LAST_IDX, '1);
    send_item(CMD_SET, 0, 0, Q_MAX);
    send_item(CMD_READ, 0, LAST_IDX, '0);
    send_item(CMD_PUSH, LAST_IDX, LAST_IDX, '0);
    send_item(CMD_PUSH, 0, 0, '0);
    send_item(CMD_ADD, LAST_IDX, LAST_IDX, 64'd1);
    send_item(CMD_READ, LAST_IDX, LAST_IDX, '0);
    send_item(CMD_READ, LAST_IDX, 0, '0);
  endtask

  // A repeated index visits its diagonal cell three times, so the second sum saturates low.
  task automatic test_duplicate_indices();
    send_item(CMD_PUSH, 5, 0, '0);
    send_item(CMD_PUSH, 5, 0, '0);
    send_item(CMD_ADD, 0, 0, Q_MIN);
    send_item(CMD_READ, 5, 5, '0);
  endtask

  task automatic test_mirror();
    send_item(CMD_PUSH, 0, 0, '0);
    send_item(CMD_PUSH, LAST_IDX, 0, '0);
    send_item(CMD_MIRROR, 0, 0, Q_MAX);
    send_item(CMD_READ, 0, LAST_IDX, '0);
  endtask

  task automatic test_empty_list_and_spare_codes();
    send_item(CMD_ADD, 0, 0, Q_MAX);
    send_item(CMD_MIRROR, LAST_IDX, LAST_IDX, '1);
    for (int code = CMD_SPARE_FIRST; code <= CMD_SPARE_LAST; code++) begin
      send_item(CMD_W'(code), LAST_IDX, LAST_IDX, '1);
    end
  endtask

  // Mostly well-formed runs: pushes, add/set or add+pushes+mirror, reads of listed cells.
  task automatic test_random_sequences();
    logic [IDX_W-1:0] picks [$];
    logic [IDX_W-1:0] a;
    logic [IDX_W-1:0] b;
    logic [CMD_W-1:0] bulk;
    int goal;
    int len;
    int kind;
    bit narrow;
    goal = items_sent + RANDOM_ITEMS;
    while (items_sent < goal) begin
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
        len = ($urandom_range(0, 19) == 0) ? $urandom_range(MAX_SET - 4, MAX_SET + 2)
                                           : $urandom_range(1, 8);
        narrow = ($urandom_range(0, 2) == 0);
        picks.delete();
        for (int k = 0; k < len; k++) begin
          a = narrow ? IDX_W'($urandom_range(0, 3)) : IDX_W'($urandom_range(0, DIM - 1));
          picks.push_back(a);
          send_item(CMD_PUSH, a, IDX_W'($urandom_range(0, DIM - 1)), draw_amount());
        end
        case ($urandom_range(0, 3))
          0, 1: bulk = CMD_ADD;
          2: bulk = CMD_SET;
          default: bulk = CMD_MIRROR;
        endcase
        if (bulk == CMD_MIRROR) begin
          send_item(CMD_ADD, IDX_W'($urandom_range(0, DIM - 1)),
                    IDX_W'($urandom_range(0, DIM - 1)), draw_amount());
          foreach (picks[k]) begin
            send_item(CMD_PUSH, picks[k], IDX_W'($urandom_range(0, DIM - 1)), '0);
          end
        end
        send_item(bulk, IDX_W'($urandom_range(0, DIM - 1)),
                  IDX_W'($urandom_range(0, DIM - 1)), draw_amount());
        repeat ($urandom_range(1, 4)) begin
          a = picks[$urandom_range(0, picks.size() - 1)];
          b = picks[$urandom_range(0, picks.size() - 1)];
          send_item(CMD_READ, a, b, draw_amount());
        end
      end else if (kind < 9) begin
        send_item(CMD_W'($urandom_range(CMD_PUSH, CMD_READ)),
                  IDX_W'($urandom_range(0, DIM - 1)),
                  IDX_W'($urandom_range(0, DIM - 1)), draw_amount());
      end else begin
        send_item(CMD_W'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST)),
                  IDX_W'($urandom_range(0, DIM - 1)),
                  IDX_W'($urandom_range(0, DIM - 1)), draw_amount());
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = CMD_PUSH;
    clear_model();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_reads_after_reset();
    test_set_and_saturating_add();
    test_duplicate_indices();
    test_mirror();
    test_empty_list_and_spare_codes();
    test_random_sequences();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    $display("Sent %0d items, %0d of them bulk commands; checked %0d results.",
             items_sent, bulk_count, results_checked);
    $display("Results with saturation: %0d, pushes dropped on a full list: %0d.",
             sat_seen, full_seen);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #16_000_000;
    $display("Timeout with %0d results still pending.", pending_results.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

[filelist.f]
sv/isa_pkg.sv
sv/isa_ram.sv
sv/isa_ctrl.sv
sv/isa_dpath.sv
sv/index_set_submatrix_accumulate_unit.sv
test/tb_index_set_submatrix_accumulate_unit.sv
